### rtl/idr_pkg.sv
// Package for the integer divide/remainder block.
// Holds the datapath width, the step counter width and the cell control structs.
// No dependencies.
package idr_pkg;

    // operand and result width
    localparam int DATA_WIDTH = 32;
    // step counter, indexes one restoring step per quotient bit
    localparam int CNT_W = $clog2(DATA_WIDTH);

    // controls from the sequencer to the cell row
    typedef struct packed {
        logic load;
        logic step;
    } t_row_ctrl;

    // controls broadcast to every cell of the row
    typedef struct packed {
        logic load;
        logic step;
        logic sel;
    } t_cell_ctrl;

endpackage

### rtl/idr_cell.sv
// One bit slice of the restoring divider: a partial remainder bit, a
// dividend/quotient bit, a divisor bit and one stage of the borrow chain.
// Depends on idr_pkg.
module idr_cell (
    input  logic                i_clk,
    input  idr_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_num_bit,
    input  logic                i_den_bit,
    input  logic                i_r_in,
    input  logic                i_q_in,
    input  logic                i_borrow_in,
    output logic                o_r,
    output logic                o_q,
    output logic                o_borrow_out
);

    logic r_rem;
    logic r_quo;
    logic r_den;
    logic n_rem;
    logic n_quo;
    logic w_diff;

    // trial subtract of the divisor from the shifted remainder bit
    assign w_diff       = i_r_in ^ r_den ^ i_borrow_in;
    assign o_borrow_out = (~i_r_in & r_den) | (~(i_r_in ^ r_den) & i_borrow_in);

    // next state: load clears the remainder, a step shifts and maybe restores
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        if (i_ctrl.load) begin
            n_rem = 1'b0;
            n_quo = i_num_bit;
        end else if (i_ctrl.step) begin
            n_rem = i_ctrl.sel ? w_diff : i_r_in;
            n_quo = i_q_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_ctrl.load) begin
            r_den <= i_den_bit;
        end
    end

    assign o_r = r_rem;
    assign o_q = r_quo;

endmodule

### rtl/idr_row.sv
// Row of DATA_WIDTH divider cells. Each step shifts remainder and quotient
// one cell up and decides the new quotient bit from the top borrow.
// Depends on idr_pkg and idr_cell.
module idr_row (
    input  logic                                i_clk,
    input  idr_pkg::t_row_ctrl                  i_ctrl,
    input  logic [idr_pkg::DATA_WIDTH-1:0]      i_num,
    input  logic [idr_pkg::DATA_WIDTH-1:0]      i_den,
    output logic [idr_pkg::DATA_WIDTH-1:0]      o_quo,
    output logic [idr_pkg::DATA_WIDTH-1:0]      o_rem
);

    logic [idr_pkg::DATA_WIDTH-1:0] w_r;
    logic [idr_pkg::DATA_WIDTH-1:0] w_q;
    logic [idr_pkg::DATA_WIDTH-1:0] w_r_in;
    logic [idr_pkg::DATA_WIDTH-1:0] w_q_in;
    logic [idr_pkg::DATA_WIDTH:0]   w_borrow;
    logic                           w_sel;
    idr_pkg::t_cell_ctrl            w_cell_ctrl;

    // remainder top bit set before the shift: subtraction always fits
    assign w_sel = w_r[idr_pkg::DATA_WIDTH-1] | ~w_borrow[idr_pkg::DATA_WIDTH];

    assign w_cell_ctrl.load = i_ctrl.load;
    assign w_cell_ctrl.step = i_ctrl.step;
    assign w_cell_ctrl.sel  = w_sel;

    // neighbor wiring: dividend top bit feeds the remainder, new quotient bit enters low
    assign w_borrow[0] = 1'b0;
    assign w_r_in      = {w_r[idr_pkg::DATA_WIDTH-2:0], w_q[idr_pkg::DATA_WIDTH-1]};
    assign w_q_in      = {w_q[idr_pkg::DATA_WIDTH-2:0], w_sel};

    for (genvar g = 0; g < idr_pkg::DATA_WIDTH; g++) begin : g_cell
        idr_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_cell_ctrl),
            .i_num_bit    (i_num[g]),
            .i_den_bit    (i_den[g]),
            .i_r_in       (w_r_in[g]),
            .i_q_in       (w_q_in[g]),
            .i_borrow_in  (w_borrow[g]),
            .o_r          (w_r[g]),
            .o_q          (w_q[g]),
            .o_borrow_out (w_borrow[g+1])
        );
    end

    assign o_quo = w_q;
    assign o_rem = w_r;

endmodule

### rtl/integer_divide_remainder.sv
// A start transfer loads the operands, then 32 restoring steps run through
// the cell row and a sign fix-up follows before the o_valid strobe.
// Start is taken only while idle; the row makes one quotient bit per cycle.
// busy is high from the cycle after a transfer until the result strobes.
// Reset (synchronous, active low) returns the sequencer to idle, no strobe.
// The receiver cannot stall: o_valid is high for exactly one cycle.
module integer_divide_remainder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_req_type,
    input  logic [idr_pkg::DATA_WIDTH-1:0]     i_dividend,
    input  logic [idr_pkg::DATA_WIDTH-1:0]     i_divisor,
    output logic                               o_valid,
    output logic [idr_pkg::DATA_WIDTH-1:0]     o_quotient,
    output logic [idr_pkg::DATA_WIDTH-1:0]     o_remainder
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIX
    } t_state;

    t_state                          r_state;
    logic [idr_pkg::CNT_W-1:0]       r_cnt;
    logic                            r_valid;
    logic                            r_neg_q;
    logic                            r_neg_r;
    logic [idr_pkg::DATA_WIDTH-1:0]  r_quotient;
    logic [idr_pkg::DATA_WIDTH-1:0]  r_remainder;

    logic                            w_accept;
    logic                            w_neg_a;
    logic                            w_neg_b;
    logic [idr_pkg::DATA_WIDTH-1:0]  w_mag_a;
    logic [idr_pkg::DATA_WIDTH-1:0]  w_mag_b;
    logic [idr_pkg::DATA_WIDTH-1:0]  w_quo;
    logic [idr_pkg::DATA_WIDTH-1:0]  w_rem;
    idr_pkg::t_row_ctrl              w_ctrl;

    assign w_accept = start & (r_state == S_IDLE);

    // operand magnitudes in signed mode; negation wraps
    assign w_neg_a = i_req_type & i_dividend[idr_pkg::DATA_WIDTH-1];
    assign w_neg_b = i_req_type & i_divisor[idr_pkg::DATA_WIDTH-1];
    assign w_mag_a = w_neg_a ? (~i_dividend + 1'b1) : i_dividend;
    assign w_mag_b = w_neg_b ? (~i_divisor + 1'b1) : i_divisor;

    assign w_ctrl.load = w_accept;
    assign w_ctrl.step = (r_state == S_RUN);

    idr_row u_row (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_num  (w_mag_a),
        .i_den  (w_mag_b),
        .o_quo  (w_quo),
        .o_rem  (w_rem)
    );

    // sequencer, sign flags and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_RUN;
                        r_cnt   <= '0;
                    end
                end
                S_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == idr_pkg::CNT_W'(idr_pkg::DATA_WIDTH - 1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload: sign flags at the transfer, signed fix-up at the end
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg_q <= w_neg_a ^ w_neg_b;
            r_neg_r <= w_neg_a;
        end
        if (r_state == S_FIX) begin
            r_quotient  <= r_neg_q ? (~w_quo + 1'b1) : w_quo;
            r_remainder <= r_neg_r ? (~w_rem + 1'b1) : w_rem;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_quotient  = r_quotient;
    assign o_remainder = r_remainder;

endmodule

### rtl/idr_checker.sv
// Port-level checker for integer_divide_remainder, attached by bind.
// Depends on idr_pkg.
module idr_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           i_req_type,
    input logic [idr_pkg::DATA_WIDTH-1:0] i_dividend,
    input logic [idr_pkg::DATA_WIDTH-1:0] i_divisor,
    input logic                           o_valid,
    input logic [idr_pkg::DATA_WIDTH-1:0] o_quotient
);

    logic w_accept;
    assign w_accept = start & ~busy;

    // a transfer always produces its result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##34 o_valid)
        else $error("result strobe missing 34 cycles after transfer");

    // block is busy right after a transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("busy not raised after transfer");

    // a strobe ends a busy period and lasts one cycle
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("strobe not at end of busy period");

    // unsigned division by one returns the dividend
    a_div_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_req_type && i_divisor == idr_pkg::DATA_WIDTH'(1))
        |-> ##34 (o_quotient == $past(i_dividend, 34)))
        else $error("unsigned divide by one gave wrong quotient");

endmodule

bind integer_divide_remainder idr_checker u_idr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_req_type (i_req_type),
    .i_dividend (i_dividend),
    .i_divisor  (i_divisor),
    .o_valid    (o_valid),
    .o_quotient (o_quotient)
);
